### hw/rtl/dhcp_lease_allocator_defines.svh
// Assertion macros for the lease allocator; they expect clk and rst_n in scope.
`ifndef DHCP_LEASE_ALLOCATOR_DEFINES_SVH
`define DHCP_LEASE_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define DLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DLA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLA_ASSERT(lbl, prop, msg)
`define DLA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hw/rtl/dla_pkg.sv
package dla_pkg;

  localparam int LEASE_SLOTS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ADDR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FIRST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LAST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFER_HOLD_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_MS      = 3'd5;

  localparam logic [31:0] RST_SERVER_ADDR   = 32'hC0A8_0101;
  localparam logic [31:0] RST_NET_MASK      = 32'hFFFF_FF00;
  localparam logic [31:0] RST_POOL_FIRST    = 32'hC0A8_0164;
  localparam logic [31:0] RST_POOL_LAST     = 32'hC0A8_01C8;
  localparam logic [31:0] RST_OFFER_HOLD_MS = 32'd60000;
  localparam logic [31:0] RST_LEASE_MS      = 32'd3600000;

  localparam logic [31:0] COOKIE_WORD  = 32'h6382_5363;
  localparam logic [7:0]  OP_BOOT_REQ  = 8'd1;
  localparam logic [7:0]  HTYPE_ETHER  = 8'd1;
  localparam logic [7:0]  HLEN_ETHER   = 8'd6;
  localparam logic [7:0]  MSG_DISCOVER = 8'd1;
  localparam logic [7:0]  MSG_REQUEST  = 8'd3;
  localparam logic [7:0]  MSG_RELEASE  = 8'd7;

  localparam logic [1:0] REPLY_NONE  = 2'd0;
  localparam logic [1:0] REPLY_OFFER = 2'd1;
  localparam logic [1:0] REPLY_ACK   = 2'd2;
  localparam logic [1:0] REPLY_NAK   = 2'd3;

  typedef struct packed {
    logic [31:0] server_addr;
    logic [31:0] net_mask;
    logic [31:0] pool_first;
    logic [31:0] pool_last;
    logic [31:0] offer_hold_ms;
    logic [31:0] lease_ms;
  } cfg_t;

  typedef struct packed {
    logic [47:0] hw;
    logic [31:0] ip;
    logic [31:0] stamp;
    logic        conf;
  } lease_entry_t;

endpackage

### hw/rtl/dla_if.sv
interface dla_in_if;
  logic        valid;
  logic        ready;
  logic        frame_ok;
  logic [7:0]  op_code;
  logic [7:0]  hw_type;
  logic [7:0]  hw_len;
  logic [31:0] relay_addr;
  logic [31:0] magic_word;
  logic [7:0]  msg_kind;
  logic [31:0] wanted_addr;
  logic [31:0] server_id;
  logic [31:0] client_addr;
  logic [47:0] hw_addr;
  logic [31:0] now_ms;

  modport source (
    output valid, frame_ok, op_code, hw_type, hw_len, relay_addr, magic_word,
           msg_kind, wanted_addr, server_id, client_addr, hw_addr, now_ms,
    input  ready
  );
  modport sink (
    input  valid, frame_ok, op_code, hw_type, hw_len, relay_addr, magic_word,
           msg_kind, wanted_addr, server_id, client_addr, hw_addr, now_ms,
    output ready
  );
endinterface

interface dla_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [31:0] your_addr;
  logic [3:0]  lease_slot;

  modport source (output valid, reply_kind, your_addr, lease_slot, input ready);
  modport sink (input valid, reply_kind, your_addr, lease_slot, output ready);
endinterface

### hw/rtl/dla_lease_mem.sv
module dla_lease_mem import dla_pkg::*; #(
  parameter int DEPTH  = LEASE_SLOTS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  lease_entry_t      wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output lease_entry_t      rdata
);

  lease_entry_t store_r [DEPTH];
  lease_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= store_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/dla_ctrl.sv
module dla_ctrl import dla_pkg::*; #(
  parameter int LEASE_SLOTS = LEASE_SLOTS_DEF,
  parameter int SLOT_W      = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  dla_in_if.sink            in_ch,
  dla_out_if.source         out_ch,
  output logic              mem_re,
  output logic [SLOT_W-1:0] mem_raddr,
  input  lease_entry_t      mem_rdata,
  output logic              mem_we,
  output logic [SLOT_W-1:0] mem_waddr,
  output lease_entry_t      mem_wdata
);

  localparam int CNT_W = $clog2(LEASE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(LEASE_SLOTS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_CAND  = 3'd2;
  localparam logic [2:0] ST_TAKEN = 3'd3;
  localparam logic [2:0] ST_REL   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic [LEASE_SLOTS-1:0] used_r, used_nxt;
  logic                   is_req_r, is_req_nxt;
  logic [47:0]            hw_r, hw_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [31:0]            pref_r, pref_nxt;
  logic                   free_found_r, free_found_nxt;
  logic [SLOT_W-1:0]      free_slot_r, free_slot_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [31:0]            ip_r, ip_nxt;
  logic [32:0]            cand_r, cand_nxt;
  logic [31:0]            last_r, last_nxt;
  logic                   pref_mode_r, pref_mode_nxt;
  logic [1:0]             res_kind_r, res_kind_nxt;
  logic                   do_wr_r, do_wr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_kind_r, out_kind_nxt;
  logic [31:0]            out_addr_r, out_addr_nxt;
  logic [3:0]             out_slot_r, out_slot_nxt;

  logic [31:0] network;
  logic [31:0] bcast;
  logic        hdr_ok;
  logic        kind_ok;
  logic        in_is_req;
  logic [31:0] req_addr;
  logic        req_bad;
  logic        slot_on;
  logic [31:0] age;
  logic [31:0] life;
  logic        live;
  logic        hw_hit;
  logic        ip_hit;
  logic        more_slots;
  logic        scan_end;
  logic        scan_st;
  logic        scan_stop;
  logic        cand_over;
  logic        cand_special;
  logic [1:0]  succ_kind;
  logic [1:0]  fail_kind;
  logic        res_has_lease;

  assign network = cfg.server_addr & cfg.net_mask;
  assign bcast   = network | ~cfg.net_mask;

  assign hdr_ok = in_ch.frame_ok && (in_ch.op_code == OP_BOOT_REQ) &&
                  (in_ch.hw_type == HTYPE_ETHER) && (in_ch.hw_len == HLEN_ETHER) &&
                  (in_ch.relay_addr == 32'd0) && (in_ch.magic_word == COOKIE_WORD) &&
                  ((in_ch.server_id == 32'd0) || (in_ch.server_id == cfg.server_addr));
  assign in_is_req = (in_ch.msg_kind == MSG_REQUEST);
  assign kind_ok   = in_is_req || (in_ch.msg_kind == MSG_DISCOVER) ||
                     (in_ch.msg_kind == MSG_RELEASE);
  assign req_addr  = (in_ch.wanted_addr != 32'd0) ? in_ch.wanted_addr : in_ch.client_addr;
  assign req_bad   = (req_addr != 32'd0) &&
                     ((req_addr < cfg.pool_first) || (req_addr > cfg.pool_last) ||
                      (req_addr == cfg.server_addr) || (req_addr == network) ||
                      (req_addr == bcast));

  // evaluation of the slot whose read came back this cycle
  assign slot_on = used_r[pend_idx_r];
  assign age     = now_r - mem_rdata.stamp;
  assign life    = mem_rdata.conf ? cfg.lease_ms : cfg.offer_hold_ms;
  assign live    = slot_on && (age < life);
  assign hw_hit  = (mem_rdata.hw == hw_r);
  assign ip_hit  = (mem_rdata.ip == cand_r[31:0]);

  assign more_slots = (idx_r < SLOT_CNT);
  assign scan_end   = !pend_v_r && !more_slots;
  assign scan_st    = (state_r == ST_LOOK) || (state_r == ST_TAKEN) || (state_r == ST_REL);

  assign cand_over    = (cand_r > {1'b0, last_r});
  assign cand_special = (cand_r[31:0] == network) || (cand_r[31:0] == bcast) ||
                        (cand_r[31:0] == cfg.server_addr);

  assign succ_kind     = is_req_r ? REPLY_ACK : REPLY_OFFER;
  assign fail_kind     = is_req_r ? REPLY_NAK : REPLY_NONE;
  assign res_has_lease = (res_kind_r == REPLY_OFFER) || (res_kind_r == REPLY_ACK);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign mem_raddr   = idx_r[SLOT_W-1:0];
  assign mem_waddr   = slot_r;
  assign mem_wdata   = '{hw: hw_r, ip: ip_r, stamp: now_r, conf: is_req_r};

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reply_kind = out_kind_r;
  assign out_ch.your_addr  = out_addr_r;
  assign out_ch.lease_slot = out_slot_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    used_nxt       = used_r;
    is_req_nxt     = is_req_r;
    hw_nxt         = hw_r;
    now_nxt        = now_r;
    pref_nxt       = pref_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    slot_nxt       = slot_r;
    ip_nxt         = ip_r;
    cand_nxt       = cand_r;
    last_nxt       = last_r;
    pref_mode_nxt  = pref_mode_r;
    res_kind_nxt   = res_kind_r;
    do_wr_nxt      = do_wr_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_addr_nxt   = out_addr_r;
    out_slot_nxt   = out_slot_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    scan_stop      = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          is_req_nxt     = in_is_req;
          hw_nxt         = in_ch.hw_addr;
          now_nxt        = in_ch.now_ms;
          idx_nxt        = '0;
          pend_v_nxt     = 1'b0;
          free_found_nxt = 1'b0;
          do_wr_nxt      = 1'b0;
          res_kind_nxt   = REPLY_NONE;
          if (!hdr_ok || !kind_ok) begin
            state_nxt = ST_FIN;
          end else if (in_ch.msg_kind == MSG_RELEASE) begin
            state_nxt = ST_REL;
          end else if (in_is_req && req_bad) begin
            res_kind_nxt = REPLY_NAK;
            state_nxt    = ST_FIN;
          end else begin
            // a discover simply drops a bad preference
            pref_nxt  = req_bad ? 32'd0 : req_addr;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (pend_v_r) begin
          if (slot_on && !live) begin
            used_nxt[pend_idx_r] = 1'b0;
          end
          if (live && hw_hit) begin
            scan_stop = 1'b1;
            slot_nxt  = pend_idx_r;
            ip_nxt    = mem_rdata.ip;
            if (is_req_r && (pref_r != 32'd0) && (mem_rdata.ip != pref_r)) begin
              res_kind_nxt = REPLY_NAK;
              do_wr_nxt    = 1'b0;
            end else begin
              res_kind_nxt = succ_kind;
              do_wr_nxt    = 1'b1;
            end
            state_nxt = ST_FIN;
          end else if (!live && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = pend_idx_r;
          end
        end else if (scan_end) begin
          if (!free_found_r) begin
            res_kind_nxt = fail_kind;
            do_wr_nxt    = 1'b0;
            state_nxt    = ST_FIN;
          end else begin
            cand_nxt      = (pref_r != 32'd0) ? {1'b0, pref_r} : {1'b0, cfg.pool_first};
            last_nxt      = (pref_r != 32'd0) ? pref_r : cfg.pool_last;
            pref_mode_nxt = (pref_r != 32'd0);
            state_nxt     = ST_CAND;
          end
        end
      end
      ST_CAND: begin
        if (cand_over) begin
          if (pref_mode_r && !is_req_r) begin
            // preferred address taken: retry a discover over the whole pool
            cand_nxt      = {1'b0, cfg.pool_first};
            last_nxt      = cfg.pool_last;
            pref_mode_nxt = 1'b0;
          end else begin
            res_kind_nxt = fail_kind;
            do_wr_nxt    = 1'b0;
            state_nxt    = ST_FIN;
          end
        end else if (cand_special) begin
          cand_nxt = cand_r + 33'd1;
        end else begin
          idx_nxt    = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_TAKEN;
        end
      end
      ST_TAKEN: begin
        if (pend_v_r && slot_on && ip_hit) begin
          scan_stop = 1'b1;
          cand_nxt  = cand_r + 33'd1;
          state_nxt = ST_CAND;
        end else if (scan_end) begin
          slot_nxt     = free_slot_r;
          ip_nxt       = cand_r[31:0];
          res_kind_nxt = succ_kind;
          do_wr_nxt    = 1'b1;
          state_nxt    = ST_FIN;
        end
      end
      ST_REL: begin
        if (pend_v_r && slot_on && hw_hit) begin
          used_nxt[pend_idx_r] = 1'b0;
        end
        if (scan_end) begin
          res_kind_nxt = REPLY_NONE;
          do_wr_nxt    = 1'b0;
          state_nxt    = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_addr_nxt  = res_has_lease ? ip_r : 32'd0;
          out_slot_nxt  = res_has_lease ? 4'(slot_r) : 4'd0;
          if (do_wr_r) begin
            mem_we           = 1'b1;
            used_nxt[slot_r] = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // one read a cycle; a stop discards the read in flight
    if (scan_st && !scan_stop) begin
      if (more_slots) begin
        mem_re       = 1'b1;
        pend_v_nxt   = 1'b1;
        pend_idx_nxt = idx_r[SLOT_W-1:0];
        idx_nxt      = idx_r + CNT_W'(1);
      end else begin
        pend_v_nxt = 1'b0;
      end
    end else if (scan_stop) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    is_req_r     <= is_req_nxt;
    hw_r         <= hw_nxt;
    now_r        <= now_nxt;
    pref_r       <= pref_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    slot_r       <= slot_nxt;
    ip_r         <= ip_nxt;
    cand_r       <= cand_nxt;
    last_r       <= last_nxt;
    pref_mode_r  <= pref_mode_nxt;
    res_kind_r   <= res_kind_nxt;
    do_wr_r      <= do_wr_nxt;
    out_kind_r   <= out_kind_nxt;
    out_addr_r   <= out_addr_nxt;
    out_slot_r   <= out_slot_nxt;
  end

endmodule

### hw/rtl/dhcp_lease_allocator.sv
// Accept to result word: a dropped message or a bad request goes straight to the result.
// A scan reads one slot a cycle; a release or a scan without lease or free slot reads them all,
// and a lease hit ends the scan. A pool search skips reserved addresses and rescans the slots
// for each other candidate up to a hit; out of candidates, a discover retries the pool, else fails.
// Throughput: one message at a time; the next is taken the cycle after a result is registered.
// Reset (synchronous, rst_n low): settings and control state take defaults, all slots go free.
`include "dhcp_lease_allocator_defines.svh"

module dhcp_lease_allocator import dla_pkg::*; #(
  parameter int LEASE_SLOTS = LEASE_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  dla_in_if.sink               in_ch,
  dla_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int SLOT_W = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

  cfg_t cfg_r, cfg_nxt;

  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  lease_entry_t      mem_rdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  lease_entry_t      mem_wdata;

  logic              in_take;
  logic              bare_reply;
  logic              bare_zero;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SERVER_ADDR:   cfg_nxt.server_addr   = cfg_data;
        CFG_NET_MASK:      cfg_nxt.net_mask      = cfg_data;
        CFG_POOL_FIRST:    cfg_nxt.pool_first    = cfg_data;
        CFG_POOL_LAST:     cfg_nxt.pool_last     = cfg_data;
        CFG_OFFER_HOLD_MS: cfg_nxt.offer_hold_ms = cfg_data;
        CFG_LEASE_MS:      cfg_nxt.lease_ms      = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{server_addr:   RST_SERVER_ADDR,
                 net_mask:      RST_NET_MASK,
                 pool_first:    RST_POOL_FIRST,
                 pool_last:     RST_POOL_LAST,
                 offer_hold_ms: RST_OFFER_HOLD_MS,
                 lease_ms:      RST_LEASE_MS};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dla_lease_mem #(
    .DEPTH  (LEASE_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dla_ctrl #(
    .LEASE_SLOTS (LEASE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  assign in_take    = in_ch.valid && in_ch.ready;
  assign bare_reply = out_ch.valid &&
                      ((out_ch.reply_kind == REPLY_NONE) || (out_ch.reply_kind == REPLY_NAK));
  assign bare_zero  = (out_ch.your_addr == 32'd0) && (out_ch.lease_slot == 4'd0);

  `DLA_ASSERT(a_no_rd_wr_overlap, !(mem_re && mem_we), "lease memory read and write overlap")
  `DLA_ASSERT(a_wr_not_on_accept, mem_we |-> !in_take, "write back while taking a word")
  `DLA_ASSERT(a_busy_after_accept, in_take |=> !in_ch.ready, "ready held after accept")
  `DLA_ASSERT(a_empty_reply_zero, bare_reply |-> bare_zero, "lease fields set without a lease")
  `DLA_ASSERT_ALWAYS(a_idle_after_reset, !rst_n |=> !out_ch.valid, "result word after reset")

endmodule

### bench/tb_dhcp_lease_allocator.sv
`timescale 1ns / 100ps

module tb_dhcp_lease_allocator;
  import dla_pkg::*;

  localparam int LEASES          = LEASE_SLOTS_DEF;
  localparam int CLIENTS         = 24;
  localparam int WATCHDOG_CYCLES = 20000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum int {
    FAULT_FRAME, FAULT_OP, FAULT_HTYPE, FAULT_HLEN, FAULT_RELAY,
    FAULT_COOKIE, FAULT_SERVER_ID, FAULT_KIND, FAULT_NO_KIND
  } fault_t;

  typedef struct packed {
    logic        chase;     // take wanted_addr from the client's lease when sent
    logic        frame_ok;
    logic [7:0]  op_code;
    logic [7:0]  hw_type;
    logic [7:0]  hw_len;
    logic [31:0] relay_addr;
    logic [31:0] magic_word;
    logic [7:0]  msg_kind;
    logic [31:0] wanted_addr;
    logic [31:0] server_id;
    logic [31:0] client_addr;
    logic [47:0] hw_addr;
    logic [31:0] now_ms;
  } dhcp_msg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [3:0]  slot;
  } dhcp_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic      in_valid = 1'b0;
  dhcp_msg_t drv = '0;
  logic      res_ready = 1'b0;

  dla_in_if  in_ch();
  dla_out_if out_ch();

  assign in_ch.valid       = in_valid;
  assign in_ch.frame_ok    = drv.frame_ok;
  assign in_ch.op_code     = drv.op_code;
  assign in_ch.hw_type     = drv.hw_type;
  assign in_ch.hw_len      = drv.hw_len;
  assign in_ch.relay_addr  = drv.relay_addr;
  assign in_ch.magic_word  = drv.magic_word;
  assign in_ch.msg_kind    = drv.msg_kind;
  assign in_ch.wanted_addr = drv.wanted_addr;
  assign in_ch.server_id   = drv.server_id;
  assign in_ch.client_addr = drv.client_addr;
  assign in_ch.hw_addr     = drv.hw_addr;
  assign in_ch.now_ms      = drv.now_ms;
  assign out_ch.ready      = res_ready;

  dhcp_lease_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: registers and lease table
  cfg_t               cfg_now;
  logic [LEASES-1:0]  slot_used = '0;
  lease_entry_t       lease_tab [LEASES];

  dhcp_msg_t   pending [$];
  dhcp_reply_t replies_due [$];

  logic [47:0] client_hw [CLIENTS];
  logic [31:0] clock_ms = 32'd1000;
  int          step_max = 10;
  int          client_span = CLIENTS;

  int sent_cnt = 0;
  int settings_cnt = 1;
  int mismatch_count = 0;
  int reply_tally [4] = '{0, 0, 0, 0};
  int quiet_cycles = 0;

  // Expire stale leases on the way, stop at the client's own lease, else claim
  // the first free slot with the first usable address.
  function automatic int lookup_lease(input logic [47:0] hw, input logic [31:0] pref,
                                      input logic [31:0] now);
    logic [31:0] net_base, bcast, age, life;
    logic [32:0] cand, stop;
    logic        taken;
    int          free_i, i;
    net_base = cfg_now.server_addr & cfg_now.net_mask;
    bcast = net_base | ~cfg_now.net_mask;
    free_i = -1;
    for (i = 0; i < LEASES; i++) begin
      if (slot_used[i]) begin
        age = now - lease_tab[i].stamp;
        life = lease_tab[i].conf ? cfg_now.lease_ms : cfg_now.offer_hold_ms;
        if (age >= life) slot_used[i] = 1'b0;
      end
      if (slot_used[i] && lease_tab[i].hw == hw) return i;
      if (!slot_used[i] && free_i < 0) free_i = i;
    end
    if (free_i < 0) return -1;
    cand = (pref != 0) ? {1'b0, pref} : {1'b0, cfg_now.pool_first};
    stop = (pref != 0) ? {1'b0, pref} : {1'b0, cfg_now.pool_last};
    while (cand <= stop) begin
      taken = (cand[31:0] == net_base) || (cand[31:0] == bcast) ||
              (cand[31:0] == cfg_now.server_addr);
      for (i = 0; i < LEASES; i++)
        if (slot_used[i] && lease_tab[i].ip == cand[31:0]) taken = 1'b1;
      if (!taken) begin
        slot_used[free_i] = 1'b1;
        lease_tab[free_i].hw = hw;
        lease_tab[free_i].ip = cand[31:0];
        lease_tab[free_i].stamp = now;
        lease_tab[free_i].conf = 1'b0;
        return free_i;
      end
      cand = cand + 1;
    end
    return -1;
  endfunction

  function automatic dhcp_reply_t answer_message(input dhcp_msg_t m);
    dhcp_reply_t r;
    logic [31:0] net_base, bcast, want;
    logic        is_req;
    int          s;
    r = '0;
    net_base = cfg_now.server_addr & cfg_now.net_mask;
    bcast = net_base | ~cfg_now.net_mask;
    is_req = (m.msg_kind == MSG_REQUEST);
    if (!m.frame_ok || m.op_code != OP_BOOT_REQ || m.hw_type != HTYPE_ETHER ||
        m.hw_len != HLEN_ETHER || m.relay_addr != 0 || m.magic_word != COOKIE_WORD)
      return r;
    if (m.server_id != 0 && m.server_id != cfg_now.server_addr) return r;
    if (m.msg_kind == MSG_RELEASE) begin
      for (s = 0; s < LEASES; s++)
        if (slot_used[s] && lease_tab[s].hw == m.hw_addr) slot_used[s] = 1'b0;
      return r;
    end
    if (m.msg_kind != MSG_DISCOVER && !is_req) return r;
    want = (m.wanted_addr != 0) ? m.wanted_addr : m.client_addr;
    if (want != 0 && (want < cfg_now.pool_first || want > cfg_now.pool_last ||
                      want == cfg_now.server_addr || want == net_base || want == bcast)) begin
      if (is_req) begin
        r.kind = REPLY_NAK;
        return r;
      end
      want = '0;
    end
    s = lookup_lease(m.hw_addr, want, m.now_ms);
    // a discover whose preference failed falls back to the whole pool
    if (s < 0 && want != 0 && !is_req) s = lookup_lease(m.hw_addr, '0, m.now_ms);
    if (s < 0 || (is_req && want != 0 && lease_tab[s].ip != want)) begin
      if (is_req) r.kind = REPLY_NAK;
      return r;
    end
    lease_tab[s].stamp = m.now_ms;
    lease_tab[s].conf = is_req;
    r.kind = is_req ? REPLY_ACK : REPLY_OFFER;
    r.addr = lease_tab[s].ip;
    r.slot = s[3:0];
    return r;
  endfunction

  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    return clock_ms;
  endfunction

  // Mostly addresses near the bottom of the pool, where leases collide
  function automatic logic [31:0] pick_addr();
    logic [31:0] net_base, span;
    net_base = cfg_now.server_addr & cfg_now.net_mask;
    span = cfg_now.pool_last - cfg_now.pool_first;
    if (cfg_now.pool_last < cfg_now.pool_first || span > 20) span = 20;
    case ($urandom_range(0, 19))
      12: return cfg_now.server_addr;
      13: return net_base;
      14: return net_base | ~cfg_now.net_mask;
      15: return cfg_now.pool_first - 1;
      16: return cfg_now.pool_last + 1;
      17: return cfg_now.pool_last;
      18, 19: return $urandom;
      default: return cfg_now.pool_first + $urandom_range(0, span);
    endcase
  endfunction

  function automatic dhcp_msg_t well_formed(input logic [7:0] kind, input logic [47:0] hw);
    dhcp_msg_t m;
    m = '0;
    m.frame_ok = 1'b1;
    m.op_code = OP_BOOT_REQ;
    m.hw_type = HTYPE_ETHER;
    m.hw_len = HLEN_ETHER;
    m.magic_word = COOKIE_WORD;
    m.msg_kind = kind;
    m.hw_addr = hw;
    m.now_ms = next_stamp();
    return m;
  endfunction

  function automatic dhcp_msg_t break_header(input dhcp_msg_t m, input fault_t f);
    logic [7:0] k;
    case (f)
      FAULT_FRAME:     m.frame_ok = 1'b0;
      FAULT_OP:        m.op_code = OP_BOOT_REQ ^ 8'($urandom_range(1, 255));
      FAULT_HTYPE:     m.hw_type = HTYPE_ETHER ^ 8'($urandom_range(1, 255));
      FAULT_HLEN:      m.hw_len = HLEN_ETHER ^ 8'($urandom_range(1, 255));
      FAULT_RELAY:     m.relay_addr = $urandom | 32'($urandom_range(1, 255));
      FAULT_COOKIE:    m.magic_word = COOKIE_WORD ^ ($urandom | 32'h1);
      FAULT_SERVER_ID: m.server_id = cfg_now.server_addr ^ ($urandom | 32'h1);
      FAULT_KIND: begin
        k = 8'($urandom_range(0, 255));
        if (k == MSG_DISCOVER || k == MSG_REQUEST || k == MSG_RELEASE) k = k + 8'd1;
        m.msg_kind = k;
      end
      default:         m.msg_kind = 8'd0;
    endcase
    return m;
  endfunction

  task automatic queue_msg(input logic [7:0] kind, input logic [47:0] hw,
                           input logic [31:0] wanted, input logic [31:0] ciaddr,
                           input logic chase);
    dhcp_msg_t m;
    m = well_formed(kind, hw);
    m.wanted_addr = wanted;
    m.client_addr = ciaddr;
    m.chase = chase;
    pending.push_back(m);
  endtask

  task automatic queue_traffic(input int count);
    dhcp_msg_t m;
    logic [63:0] raw;
    logic [47:0] hw;
    int n, r;
    n = 0;
    while (n < count) begin
      hw = client_hw[$urandom_range(0, client_span - 1)];
      r = $urandom_range(0, 99);
      if (r < 42) m = well_formed(MSG_DISCOVER, hw);
      else if (r < 72) m = well_formed(MSG_REQUEST, hw);
      else m = well_formed(MSG_RELEASE, hw);
      m.wanted_addr = $urandom_range(0, 1) ? 32'h0 : pick_addr();
      m.client_addr = ($urandom_range(0, 9) < 3) ? pick_addr() : 32'h0;
      case ($urandom_range(0, 19))
        0, 1, 2: m.server_id = cfg_now.server_addr;
        3:       m.server_id = $urandom;
        default: m.server_id = '0;
      endcase
      if (m.msg_kind == MSG_REQUEST) m.chase = ($urandom_range(0, 9) < 6);
      if (r >= 82) begin
        if ($urandom_range(0, 3) == 0) begin
          raw = {$urandom, $urandom};
          m.hw_addr = raw[47:0];
        end else begin
          m = break_header(m, fault_t'($urandom_range(0, FAULT_NO_KIND)));
        end
      end
      pending.push_back(m);
      n++;
      // follow an offer with the request that confirms it
      if (r < 42 && $urandom_range(0, 1) == 1) begin
        queue_msg(MSG_REQUEST, hw, '0, '0, 1'b1);
        n++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SERVER_ADDR:   cfg_now.server_addr = val;
      CFG_NET_MASK:      cfg_now.net_mask = val;
      CFG_POOL_FIRST:    cfg_now.pool_first = val;
      CFG_POOL_LAST:     cfg_now.pool_last = val;
      CFG_OFFER_HOLD_MS: cfg_now.offer_hold_ms = val;
      CFG_LEASE_MS:      cfg_now.lease_ms = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every word is sent and every reply is back
  task automatic settle();
    while (pending.size() != 0 || replies_due.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] sa, input logic [31:0] nm,
                           input logic [31:0] pf, input logic [31:0] pl,
                           input logic [31:0] oh, input logic [31:0] lm,
                           input int step, input int span, input int count);
    write_reg(CFG_SERVER_ADDR, sa);
    write_reg(CFG_NET_MASK, nm);
    write_reg(CFG_POOL_FIRST, pf);
    write_reg(CFG_POOL_LAST, pl);
    write_reg(CFG_OFFER_HOLD_MS, oh);
    write_reg(CFG_LEASE_MS, lm);
    settings_cnt++;
    clock_ms = $urandom;
    step_max = step;
    client_span = span;
    queue_traffic(count);
    settle();
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // Driver: present one word at a time, predict its reply when it is taken
  int   in_gap = 0;
  logic in_calm = 1'b0;

  always @(posedge clk) begin : driver
    dhcp_msg_t   nxt;
    dhcp_reply_t due;
    int          s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ch.ready) begin
        due = answer_message(drv);
        replies_due.push_back(due);
        sent_cnt++;
      end
      if (!in_valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          if (nxt.chase)
            for (s = 0; s < LEASES; s++)
              if (slot_used[s] && lease_tab[s].hw == nxt.hw_addr)
                nxt.wanted_addr = lease_tab[s].ip;
          drv <= nxt;
          in_valid <= 1'b1;
          in_gap <= in_calm ? 0 : $urandom_range(0, 5);
          if ($urandom_range(0, 49) == 0) in_calm <= !in_calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply with the oldest prediction, then at random stall a while
  int   res_wait = 0;
  logic res_calm = 1'b0;

  always @(posedge clk) begin : monitor
    dhcp_reply_t want;
    int          stall;
    if (!rst_n) begin
      res_ready <= 1'b0;
      res_wait <= 0;
    end else if (out_ch.valid && res_ready) begin
      if (replies_due.size() == 0) begin
        mismatch_count++;
        $error("reply with nothing outstanding: kind %0d addr %0h slot %0d",
               out_ch.reply_kind, out_ch.your_addr, out_ch.lease_slot);
      end else begin
        want = replies_due.pop_front();
        if (out_ch.reply_kind !== want.kind)
          note_mismatch("reply_kind", 32'(want.kind), 32'(out_ch.reply_kind));
        if (out_ch.your_addr !== want.addr)
          note_mismatch("your_addr", want.addr, out_ch.your_addr);
        if (out_ch.lease_slot !== want.slot)
          note_mismatch("lease_slot", 32'(want.slot), 32'(out_ch.lease_slot));
      end
      reply_tally[out_ch.reply_kind]++;
      stall = res_calm ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 49) == 0) res_calm <= !res_calm;
      if (stall != 0) begin
        res_ready <= 1'b0;
        res_wait <= stall;
      end
    end else if (res_wait != 0) begin
      res_wait <= res_wait - 1;
      if (res_wait == 1) res_ready <= 1'b1;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ch.ready) || (out_ch.valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES) begin
      $error("no handshake for %0d cycles, %0d replies outstanding",
             WATCHDOG_CYCLES, replies_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] raw;
    logic [31:0] sa, nm, pf;
    int          i, k;
    cfg_now = {RST_SERVER_ADDR, RST_NET_MASK, RST_POOL_FIRST, RST_POOL_LAST,
               RST_OFFER_HOLD_MS, RST_LEASE_MS};
    client_hw[0] = '0;
    client_hw[1] = '1;
    for (i = 2; i < CLIENTS; i++) begin
      raw = {$urandom, $urandom};
      client_hw[i] = raw[47:0];
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values in force: walk the main paths by hand
    queue_msg(MSG_DISCOVER, client_hw[2], '0, '0, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[2], '0, '0, 1'b1);
    queue_msg(MSG_REQUEST, client_hw[2], RST_POOL_FIRST + 5, '0, 1'b0);
    queue_msg(MSG_DISCOVER, client_hw[3], RST_POOL_FIRST + 7, '0, 1'b0);
    queue_msg(MSG_DISCOVER, client_hw[4], RST_SERVER_ADDR, '0, 1'b0);
    // preference already held by another client: retry from the pool
    queue_msg(MSG_DISCOVER, client_hw[5], RST_POOL_FIRST + 7, '0, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[6], RST_POOL_LAST + 1, '0, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[6], '0, RST_POOL_FIRST + 3, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[7], RST_SERVER_ADDR | ~RST_NET_MASK, '0, 1'b0);
    queue_msg(MSG_RELEASE, client_hw[2], '0, '0, 1'b0);
    queue_msg(MSG_DISCOVER, client_hw[0], '0, '0, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[1], RST_POOL_LAST, '0, 1'b0);
    for (i = 0; i <= FAULT_NO_KIND; i++)
      pending.push_back(break_header(well_formed(MSG_DISCOVER, client_hw[8]), fault_t'(i)));
    queue_msg(MSG_REQUEST, client_hw[9], '0, '0, 1'b0);
    pending[pending.size() - 1].server_id = RST_SERVER_ADDR;
    // let the unconfirmed offers lapse, keep the confirmed ones
    clock_ms = clock_ms + 32'd70000;
    queue_msg(MSG_DISCOVER, client_hw[3], '0, '0, 1'b0);
    queue_msg(MSG_REQUEST, client_hw[6], '0, '0, 1'b0);

    step_max = 20000;
    queue_traffic(100);
    settle();

    // Shortest lifetimes: almost everything lapses between messages
    run_phase(RST_SERVER_ADDR, RST_NET_MASK, RST_POOL_FIRST, RST_POOL_LAST,
              32'd1, 32'd1, 2, CLIENTS, 250);
    // Tiny pool around the server, leases never lapse: pool runs dry
    run_phase(32'h0A00_0003, 32'hFFFF_FFF8, 32'h0A00_0001, 32'h0A00_0006,
              '1, '1, 5000, CLIENTS, 250);
    // Whole address space, more clients than slots: table fills
    run_phase('0, '0, '0, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 100000, CLIENTS, 250);
    // Top of the address space, server equals network and broadcast
    run_phase('1, '1, 32'hFFFF_FFF0, '1, 32'd30000, 32'd90000, 10000, 12, 250);
    // Empty pool
    run_phase(RST_SERVER_ADDR, RST_NET_MASK, RST_POOL_LAST, RST_POOL_FIRST,
              RST_OFFER_HOLD_MS, RST_LEASE_MS, 20000, CLIENTS, 60);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, '1);
    queue_traffic(100);
    settle();

    for (k = 0; k < 3; k++) begin
      sa = $urandom;
      i = $urandom_range(0, 32);
      nm = (i == 0) ? 32'h0 : ~32'h0 << (32 - i);
      pf = (sa & nm) + $urandom_range(0, 8);
      run_phase(sa, nm, pf, pf + $urandom_range(0, 40), $urandom_range(1, 100000),
                $urandom_range(1, 400000), $urandom_range(1, 30000),
                $urandom_range(4, CLIENTS), 220);
    end

    run_phase(RST_SERVER_ADDR, RST_NET_MASK, RST_POOL_FIRST, RST_POOL_LAST,
              RST_OFFER_HOLD_MS, RST_LEASE_MS, 20000, 20, 300);

    repeat (40) @(posedge clk);
    $display("%0d client messages sent under %0d register settings", sent_cnt, settings_cnt);
    $display("replies seen: %0d offer, %0d ack, %0d nak, %0d silent; %0d field mismatches",
             reply_tally[REPLY_OFFER], reply_tally[REPLY_ACK], reply_tally[REPLY_NAK],
             reply_tally[REPLY_NONE], mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dla_pkg.sv
hw/rtl/dla_if.sv
hw/rtl/dla_lease_mem.sv
hw/rtl/dla_ctrl.sv
hw/rtl/dhcp_lease_allocator.sv
bench/tb_dhcp_lease_allocator.sv
